// ===== hw/rtl/bms_pkg.sv =====
// Package for box mean / standard deviation: shared widths, limits, register codes.
// No dependencies.
package bms_pkg;

  localparam int SampleW = 8;
  localparam int CfgW    = 7;
  localparam int CfgIdxW = 2;

  localparam int MAX_BOX_LINES   = 64;
  localparam int MAX_BOX_SAMPLES = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BOX_LINES   = 2'd0,
    REG_BOX_SAMPLES = 2'd1,
    REG_VAR_ENABLE  = 2'd2
  } reg_idx_e;

endpackage

// ===== hw/rtl/bms_if.sv =====
// Channel interfaces for box mean / standard deviation.
// Depends on bms_pkg.
interface bms_sample_if import bms_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface bms_result_if import bms_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] mean_value;
  logic [SampleW-1:0] std_dev;

  modport source (output valid, output mean_value, output std_dev, input ready);
  modport sink   (input valid, input mean_value, input std_dev, output ready);
endinterface

// ===== hw/rtl/bms_front.sv =====
// Front end: accepts samples, accumulates sum, sum of squares and count per box.
// Depends on bms_pkg and bms_if.
module bms_front import bms_pkg::*; #(
  parameter int MaxBoxLines   = MAX_BOX_LINES,
  parameter int MaxBoxSamples = MAX_BOX_SAMPLES,
  localparam int CntW = $clog2(MaxBoxLines * MaxBoxSamples + 1),
  localparam int SumW = SampleW + CntW,
  localparam int SqW  = 2 * SampleW + CntW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bms_sample_if.sink       sample_i,
  input  logic [CfgW-1:0]  box_lines_i,
  input  logic [CfgW-1:0]  box_samples_i,
  input  logic             var_en_i,
  input  logic             push_ready_i,
  output logic             push_valid_o,
  output logic [SumW-1:0]  sum_o,
  output logic [SqW-1:0]   sumsq_o,
  output logic [CntW-1:0]  cnt_o,
  output logic             var_en_o
);

  localparam int LinesW   = $clog2(MaxBoxLines + 1);
  localparam int SamplesW = $clog2(MaxBoxSamples + 1);

  logic [SumW-1:0] sum_q, sum_d;
  logic [SqW-1:0]  sumsq_q, sumsq_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [LinesW-1:0]   lines_c;
  logic [SamplesW-1:0] samples_c;
  logic [LinesW+SamplesW-1:0] n_full;
  logic [CntW-1:0]  n_box;
  logic [2*SampleW-1:0] sq;
  logic accept, done;

  // clamp box dimensions; zero acts as one
  always_comb begin
    if (box_lines_i == '0) begin
      lines_c = LinesW'(1);
    end else if (32'(box_lines_i) > MaxBoxLines) begin
      lines_c = LinesW'(MaxBoxLines);
    end else begin
      lines_c = LinesW'(box_lines_i);
    end
    if (box_samples_i == '0) begin
      samples_c = SamplesW'(1);
    end else if (32'(box_samples_i) > MaxBoxSamples) begin
      samples_c = SamplesW'(MaxBoxSamples);
    end else begin
      samples_c = SamplesW'(box_samples_i);
    end
  end

  assign n_full = lines_c * samples_c;
  assign n_box  = CntW'(n_full);

  assign sample_i.ready = push_ready_i;
  assign accept = sample_i.valid & sample_i.ready;

  assign sq      = sample_i.sample * sample_i.sample;
  assign sum_o   = sum_q + SumW'(sample_i.sample);
  assign sumsq_o = sumsq_q + SqW'(sq);
  assign cnt_o   = cnt_q + CntW'(1);
  assign done    = cnt_o >= n_box;
  assign var_en_o     = var_en_i;
  assign push_valid_o = accept & done;

  always_comb begin
    sum_d   = sum_q;
    sumsq_d = sumsq_q;
    cnt_d   = cnt_q;
    if (accept) begin
      if (done) begin
        sum_d   = '0;
        sumsq_d = '0;
        cnt_d   = '0;
      end else begin
        sum_d   = sum_o;
        sumsq_d = sumsq_o;
        cnt_d   = cnt_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      sumsq_q <= '0;
      cnt_q   <= '0;
    end else begin
      sum_q   <= sum_d;
      sumsq_q <= sumsq_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/bms_queue.sv =====
// Two-entry job queue between front and back end.
// No package dependencies.
module bms_queue #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             not_full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] data_q [2];
  logic             wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign not_full_o = cnt_q != 2'd2;
  assign valid_o    = cnt_q != 2'd0;
  assign data_o     = data_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/bms_back.sv =====
// Back end: rounded mean by restoring division, rounded stddev by bitwise search.
// Depends on bms_pkg and bms_if.
module bms_back import bms_pkg::*; #(
  parameter int MaxBoxLines   = MAX_BOX_LINES,
  parameter int MaxBoxSamples = MAX_BOX_SAMPLES,
  localparam int CntW = $clog2(MaxBoxLines * MaxBoxSamples + 1),
  localparam int SumW = SampleW + CntW,
  localparam int SqW  = 2 * SampleW + CntW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  logic [SumW-1:0] job_sum_i,
  input  logic [SqW-1:0]  job_sumsq_i,
  input  logic [CntW-1:0] job_cnt_i,
  input  logic            job_var_en_i,
  output logic            job_pop_o,
  bms_result_if.source    result_o
);

  localparam int RemW  = SumW + 1;
  localparam int ProdW = CntW + SqW;
  localparam int D4W   = ProdW + 2;
  localparam int OddW  = SampleW + 1;
  localparam int SqrW  = 2 * OddW;
  localparam int BitW  = $clog2(SampleW);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_DIFF = 6'b000100,
    ST_SQR  = 6'b001000,
    ST_TEST = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [SumW-1:0]    sum_q;
  logic [SqW-1:0]     sumsq_q;
  logic [CntW-1:0]    cnt_q;
  logic               sdz_q;
  logic [RemW-1:0]    rem_q;
  logic [CntW:0]      div_q;
  logic [SampleW-1:0] quo_q, s_q;
  logic [BitW-1:0]    bit_q;
  logic [ProdW-1:0]   prod_q;
  logic [2*SumW-1:0]  sqs_q;
  logic [2*CntW-1:0]  cc_q;
  logic [D4W-1:0]     d4_q;
  logic [SqrW-1:0]    sqr_q;
  logic               out_valid_q;
  logic [SampleW-1:0] out_mean_q, out_sd_q;

  logic [SampleW-1:0] trial;
  logic [OddW-1:0]    odd;
  logic [RemW-1:0]    dshift;
  logic [D4W-1:0]     lhs;
  logic               out_free;

  assign trial  = s_q | (SampleW'(1) << bit_q);
  assign odd    = {trial, 1'b0} - OddW'(1);
  assign dshift = RemW'(div_q) << bit_q;
  assign lhs    = D4W'(sqr_q * cc_q);
  assign out_free  = ~out_valid_q | result_o.ready;
  assign job_pop_o = (state_q == ST_IDLE) & job_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (job_valid_i) state_d = ST_PREP;
      ST_PREP: state_d = ST_DIFF;
      ST_DIFF: state_d = ST_SQR;
      ST_SQR:  state_d = ST_TEST;
      ST_TEST: state_d = (bit_q == '0) ? ST_DONE : ST_SQR;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        sum_q   <= job_sum_i;
        sumsq_q <= job_sumsq_i;
        cnt_q   <= job_cnt_i;
        sdz_q   <= ~job_var_en_i | (job_cnt_i < CntW'(2));
        rem_q   <= {job_sum_i, 1'b0} + RemW'(job_cnt_i);
        div_q   <= {job_cnt_i, 1'b0};
        quo_q   <= '0;
        s_q     <= '0;
        bit_q   <= BitW'(SampleW - 1);
      end
      ST_PREP: begin
        prod_q <= cnt_q * sumsq_q;
        sqs_q  <= sum_q * sum_q;
        cc_q   <= cnt_q * (cnt_q - CntW'(1));
      end
      ST_DIFF: begin
        if (ProdW'(sqs_q) < prod_q) begin
          d4_q <= {prod_q - ProdW'(sqs_q), 2'b00};
        end else begin
          d4_q <= '0;
        end
      end
      ST_SQR: begin
        sqr_q <= odd * odd;
        if (rem_q >= dshift) begin
          rem_q        <= rem_q - dshift;
          quo_q[bit_q] <= 1'b1;
        end
      end
      ST_TEST: begin
        if (lhs <= d4_q) begin
          s_q <= trial;
        end
        bit_q <= bit_q - BitW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_mean_q <= quo_q;
          out_sd_q   <= sdz_q ? '0 : s_q;
        end
      end
      default: ;
    endcase
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.mean_value = out_mean_q;
  assign result_o.std_dev    = out_sd_q;

`ifndef ASSERT_OFF
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> state_q == ST_IDLE) else $error("pop outside idle");
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE)) else $error("result not from done");
  a_last_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TEST && bit_q == '0) |=> state_q == ST_DONE)
    else $error("search did not finish");
`endif

endmodule

// ===== hw/rtl/box_mean_stddev.sv =====
// Top level of box mean / standard deviation: config registers, front, queue, back.
// Depends on bms_pkg, bms_if, bms_front, bms_queue, bms_back.
//
//  channel    dir   handshake       payload
//  sample_i   in    valid/ready     sample[7:0]
//  result_o   out   valid/ready     mean_value[7:0], std_dev[7:0]
//  cfg        in    cfg_we_i        cfg_idx_i[1:0], cfg_wdata_i[6:0]
//
// One sample transaction per cycle is taken while sample_i.ready is high; a box
// ends on its last sample. Back end steps: load, prepare, difference, a
// search/divide pair per result bit, output load; the 2-entry queue absorbs short
// boxes, beyond that sample_i.ready drops. No clearing pass: accumulators clear
// at reset. A result waits in the output register while the next box is computed.
module box_mean_stddev import bms_pkg::*; #(
  parameter int MaxBoxLines   = MAX_BOX_LINES,
  parameter int MaxBoxSamples = MAX_BOX_SAMPLES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  bms_sample_if.sink         sample_i,
  bms_result_if.source       result_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  localparam int CntW = $clog2(MaxBoxLines * MaxBoxSamples + 1);
  localparam int SumW = SampleW + CntW;
  localparam int SqW  = 2 * SampleW + CntW;
  localparam int JobW = SumW + SqW + CntW + 1;

  logic [CfgW-1:0] lines_q, samples_q;
  logic            var_q;

  // config registers; unknown index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_q   <= CfgW'(1);
      samples_q <= CfgW'(1);
      var_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_BOX_LINES:   lines_q   <= cfg_wdata_i;
        REG_BOX_SAMPLES: samples_q <= cfg_wdata_i;
        REG_VAR_ENABLE:  var_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic            push_valid, push_ready, job_valid, job_pop;
  logic [SumW-1:0] f_sum, b_sum;
  logic [SqW-1:0]  f_sumsq, b_sumsq;
  logic [CntW-1:0] f_cnt, b_cnt;
  logic            f_var, b_var;
  logic [JobW-1:0] job_in, job_out;

  bms_front #(
    .MaxBoxLines  (MaxBoxLines),
    .MaxBoxSamples(MaxBoxSamples)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (sample_i),
    .box_lines_i  (lines_q),
    .box_samples_i(samples_q),
    .var_en_i     (var_q),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .sum_o        (f_sum),
    .sumsq_o      (f_sumsq),
    .cnt_o        (f_cnt),
    .var_en_o     (f_var)
  );

  assign job_in = {f_var, f_cnt, f_sumsq, f_sum};

  bms_queue #(.Width(JobW)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_valid),
    .push_data_i(job_in),
    .not_full_o (push_ready),
    .pop_i      (job_pop),
    .valid_o    (job_valid),
    .data_o     (job_out)
  );

  assign {b_var, b_cnt, b_sumsq, b_sum} = job_out;

  bms_back #(
    .MaxBoxLines  (MaxBoxLines),
    .MaxBoxSamples(MaxBoxSamples)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_sum_i   (b_sum),
    .job_sumsq_i (b_sumsq),
    .job_cnt_i   (b_cnt),
    .job_var_en_i(b_var),
    .job_pop_o   (job_pop),
    .result_o    (result_o)
  );

endmodule

// ===== verif/box_mean_stddev_tb.sv =====
// Testbench for box_mean_stddev: streams pixel samples, predicts box mean and
// sample standard deviation per box, and checks every result transaction.
// Depends on bms_pkg, bms_if and the box_mean_stddev RTL.
`timescale 1ns / 100ps

module box_mean_stddev_tb;
  import bms_pkg::*;

  typedef struct packed {
    logic [7:0] mean_value;
    logic [7:0] std_dev;
  } box_stat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = REG_BOX_LINES;
  logic [CfgW-1:0] cfg_wdata_i = '0;

  bms_sample_if sample_ch ();
  bms_result_if result_ch ();

  box_mean_stddev DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample_ch.sink),
    .result_o   (result_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: shadow registers and accumulators.
  logic [6:0]  shd_lines = 7'd1;
  logic [6:0]  shd_samples = 7'd1;
  logic        shd_var = 1'b0;
  logic [19:0] run_sum = '0;
  logic [27:0] run_sumsq = '0;
  logic [12:0] run_count = '0;

  logic [7:0]  pending_samples[$];
  box_stat_t   expected_stats[$];
  int          n_errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          recv_holdoff = 1'b0;
  int          quiet_cycles = 0;

  localparam int QuietLimit = 20000;

  function automatic int unsigned clamp_dim(logic [6:0] v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  // Largest s with s == 0 or (2s-1)^2 * c(c-1) <= 4(c*sumsq - sum^2).
  function automatic logic [7:0] sample_stddev(longint unsigned sum,
                                               longint unsigned sumsq,
                                               longint unsigned c);
    longint unsigned sq, prod, d4, cc, t;
    int unsigned lo, hi, mid;
    sq = sum * sum;
    prod = c * sumsq;
    cc = c * (c - 1);
    lo = 0;
    hi = 255;
    if (prod <= sq) return 8'd0;
    d4 = (prod - sq) * 4;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      if (t * t * cc <= d4) lo = mid;
      else hi = mid - 1;
    end
    return lo[7:0];
  endfunction

  // Update accumulators for one accepted sample; queue a result on box end.
  task automatic accumulate_sample(logic [7:0] s);
    int unsigned n;
    longint unsigned c, mean;
    box_stat_t st;
    n = clamp_dim(shd_lines) * clamp_dim(shd_samples);
    run_sum += s;
    run_sumsq += s * s;
    run_count += 1;
    if (run_count >= n) begin
      c = run_count;
      mean = (2 * longint'(run_sum) + c) / (2 * c);
      if (mean > 255) mean = 255;
      st.mean_value = mean[7:0];
      st.std_dev = (shd_var && c > 1) ? sample_stddev(run_sum, run_sumsq, c) : 8'd0;
      expected_stats.push_back(st);
      run_sum = '0;
      run_sumsq = '0;
      run_count = '0;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    n_errors++;
  endtask

  // Driver: one sample per cycle from the pending queue, held on stall, random idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_ch.valid <= 1'b0;
      sample_ch.sample <= '0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        accumulate_sample(sample_ch.sample);
        void'(pending_samples.pop_front());
      end
      if (!(sample_ch.valid && !sample_ch.ready)) begin
        // Previous transaction done or nothing offered: choose the next.
        if (pending_samples.size() > (sample_ch.valid && sample_ch.ready ? 0 : 0) &&
            pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_ch.valid <= 1'b1;
          sample_ch.sample <= pending_samples[0];
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest expected box statistic.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_stats.size() == 0) begin
          report_mismatch("unexpected result", result_ch.mean_value, -1);
        end else begin
          box_stat_t want;
          want = expected_stats.pop_front();
          if (result_ch.mean_value !== want.mean_value)
            report_mismatch("mean_value", result_ch.mean_value, want.mean_value);
          if (result_ch.std_dev !== want.std_dev)
            report_mismatch("std_dev", result_ch.std_dev, want.std_dev);
        end
      end
      result_ch.ready <= !recv_holdoff && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [6:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_BOX_LINES: shd_lines = val;
      REG_BOX_SAMPLES: shd_samples = val;
      default: shd_var = val[0];
    endcase
  endtask

  // Block idle: all samples taken, all results seen, back end drained.
  task automatic wait_drained();
    while (pending_samples.size() != 0 || sample_ch.valid) @(posedge clk_i);
    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_box(logic [6:0] l, logic [6:0] s, logic v);
    wait_drained();
    write_reg(REG_BOX_LINES, l);
    write_reg(REG_BOX_SAMPLES, s);
    write_reg(REG_VAR_ENABLE, {6'd0, v});
  endtask

  // Queue whole boxes of random content; mode picks the value spread.
  task automatic queue_boxes(int boxes);
    int unsigned n, mode, base;
    n = clamp_dim(shd_lines) * clamp_dim(shd_samples);
    for (int b = 0; b < boxes; b++) begin
      mode = $urandom_range(3);
      base = $urandom_range(255);
      for (int k = 0; k < n; k++) begin
        case (mode)
          0: pending_samples.push_back(8'($urandom_range(255)));
          1: pending_samples.push_back(base[7:0]);
          2: pending_samples.push_back($urandom_range(1) ? 8'hFF : 8'h00);
          default: pending_samples.push_back(8'(base + $urandom_range(3)));
        endcase
      end
    end
  endtask

  initial begin
    int phase;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset config gives one-sample boxes, std_dev forced zero.
    pending_samples.push_back(8'h00);
    pending_samples.push_back(8'hFF);
    pending_samples.push_back(8'h80);
    // n=1 with variance enabled still reports zero.
    set_box(7'd1, 7'd1, 1'b1);
    pending_samples.push_back(8'h55);
    pending_samples.push_back(8'hAA);
    // Two samples: half-way rounding and maximal spread.
    set_box(7'd1, 7'd2, 1'b1);
    pending_samples.push_back(8'h00);
    pending_samples.push_back(8'hFF);
    pending_samples.push_back(8'h01);
    pending_samples.push_back(8'h02);
    pending_samples.push_back(8'h07);
    pending_samples.push_back(8'h07);
    // Zero dimensions act as one; oversize dimensions saturate at 64.
    set_box(7'd0, 7'd3, 1'b1);
    pending_samples.push_back(8'h10);
    pending_samples.push_back(8'h20);
    pending_samples.push_back(8'h31);
    set_box(7'd2, 7'd0, 1'b0);
    pending_samples.push_back(8'hFF);
    pending_samples.push_back(8'hFE);
    set_box(7'd127, 7'd1, 1'b1);
    queue_boxes(1);
    set_box(7'd1, 7'd100, 1'b1);
    queue_boxes(1);
    // Mid-size box once, all samples extreme.
    set_box(7'd8, 7'd12, 1'b1);
    for (int k = 0; k < 96; k++) pending_samples.push_back(k[0] ? 8'hFF : 8'h00);

    // Size shrunk mid-box: box completes with the larger actual count.
    set_box(7'd1, 7'd5, 1'b1);
    pending_samples.push_back(8'h03);
    pending_samples.push_back(8'h09);
    pending_samples.push_back(8'h0C);
    wait_drained();
    write_reg(REG_BOX_SAMPLES, 7'd2);
    pending_samples.push_back(8'h40);

    // Random phases with small boxes under the four idling profiles.
    for (phase = 0; phase < 16; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 67; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 67; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      set_box(7'($urandom_range(0, 3)), 7'($urandom_range(0, 3)), 1'($urandom_range(1)));
      queue_boxes(phase == 4 ? 12 : 4);
      if (phase == 4) begin
        // Long receiver hold-off while samples keep coming.
        recv_holdoff = 1'b1;
        repeat (300) @(posedge clk_i);
        recv_holdoff = 1'b0;
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (n_errors == 0 && expected_stats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bms_pkg.sv
hw/rtl/bms_if.sv
hw/rtl/bms_front.sv
hw/rtl/bms_queue.sv
hw/rtl/bms_back.sv
hw/rtl/box_mean_stddev.sv
verif/box_mean_stddev_tb.sv
